@@ hdl/bsuvw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsuvw_pkg
// shared types and constants of the baseline to station uvw solver
// ----------------------------------------------------------------------------
package bsuvw_pkg;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned IDX_W   = 6;
	localparam logic [1:0] REG_STATION_COUNT = 2'd0;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t u;
		coord_t v;
		coord_t w;
	} vec3_t;

	// saturating add or subtract of two signed 32-bit values
	function automatic coord_t sat_addsub(input coord_t a, input coord_t b, input logic sub);
		logic signed [COORD_W:0] r;
		r = sub ? ({a[COORD_W-1], a} - {b[COORD_W-1], b})
			: ({a[COORD_W-1], a} + {b[COORD_W-1], b});
		if (r[COORD_W] != r[COORD_W-1])
			sat_addsub = r[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		else
			sat_addsub = r[COORD_W-1:0];
	endfunction
endpackage
`default_nettype wire

@@ hdl/bsuvw_bl_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsuvw_bl_mem
// baseline store: one write port, one registered read port
// ----------------------------------------------------------------------------
module bsuvw_bl_mem import bsuvw_pkg::*; #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [IDX_W-1:0]  wp,
	input  wire logic [IDX_W-1:0]  wq,
	input  wire vec3_t             wvec,
	input  wire logic [AW-1:0]     raddr,
	output      logic [IDX_W-1:0]  rp,
	output      logic [IDX_W-1:0]  rq,
	output      vec3_t             rvec
);
	localparam int unsigned DW = 2*IDX_W + 3*COORD_W;
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= {wp, wq, wvec};
		rd_q <= mem[raddr];
	end

	assign rp   = rd_q[DW-1 -: IDX_W];
	assign rq   = rd_q[DW-IDX_W-1 -: IDX_W];
	assign rvec = rd_q[3*COORD_W-1:0];
endmodule
`default_nettype wire

@@ hdl/baseline_to_station_uvw_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baseline_to_station_uvw_solver
// loads baselines, then solves and emits per-station u,v,w coordinates
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | apb psel / penable / pready
//
// a baseline item without last is stored while there is room. an item with last
// starts solving: a marking pass over the stored baselines, a pass over the
// stations to zero the isolated ones, then per group reference repeated passes
// over the baselines, each baseline taking a baseline read, a station read and
// a station update, with an end check after each pass, then a fetch and an output
// step per result, held while the output is stalled. the input stalls from the
// last item until the cycle after the solver returns to loading. reset clears control state only.
// ----------------------------------------------------------------------------
module baseline_to_station_uvw_solver import bsuvw_pkg::*; #(
	parameter int unsigned MAX_STATIONS  = 64,
	parameter int unsigned MAX_BASELINES = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output      logic [31:0]         prdata,
	output      logic                pready,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [IDX_W-1:0]    station_p,
	input  wire logic [IDX_W-1:0]    station_q,
	input  wire logic signed [31:0]  baseline_u,
	input  wire logic signed [31:0]  baseline_v,
	input  wire logic signed [31:0]  baseline_w,
	input  wire logic                last,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [IDX_W-1:0]    station_index,
	output      logic signed [31:0]  station_u,
	output      logic signed [31:0]  station_v,
	output      logic signed [31:0]  station_w,
	output      logic                final_station
);
	localparam int unsigned AW = (MAX_BASELINES > 1) ? $clog2(MAX_BASELINES) : 1;
	localparam int unsigned CW = $clog2(MAX_BASELINES + 1);
	localparam int unsigned SW = $clog2(MAX_STATIONS + 1);
	localparam int unsigned NS = MAX_STATIONS;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_MARK = 3'd1;
	localparam logic [2:0] ST_REF  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_MRK2 = 3'd6;
	localparam logic [2:0] ST_FET  = 3'd7;

	logic [2:0]        state_q;
	logic [6:0]        station_count_q;
	logic [CW-1:0]     loaded_q;
	logic [CW-1:0]     bidx_q;
	logic [SW-1:0]     n_q;
	logic [SW-1:0]     ref_q;
	logic [SW-1:0]     found_q;
	logic [SW-1:0]     emit_q;
	logic [NS-1:0]     known_q;
	logic              reach_q;
	logic              hold_q;
	logic              emit_fetch_q;
	vec3_t             sol_mem [NS];
	vec3_t             sol_p_q, sol_q_q;

	logic              mem_we;
	logic [AW-1:0]     raddr;
	logic [IDX_W-1:0]  rp, rq;
	vec3_t             rvec;
	logic [SW-1:0]     n_eff;
	logic              use_b;
	logic              kp, kq;
	logic [IDX_W-1:0]  sol_ra2;

	// config register
	assign pready = 1'b1;
	assign prdata = {25'd0, station_count_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			station_count_q <= 7'd64;
		else if (psel && penable && pwrite && paddr == REG_STATION_COUNT)
			station_count_q <= pwdata[6:0];
	end

	// effective station count saturated to 1..MAX_STATIONS
	always_comb begin
		if (station_count_q == 7'd0)
			n_eff = SW'(1);
		else if (32'(station_count_q) > NS)
			n_eff = SW'(NS);
		else
			n_eff = SW'(station_count_q);
	end

	assign in_stall = (state_q != ST_LOAD) || hold_q;
	assign mem_we   = in_valid && !in_stall && (32'(loaded_q) < MAX_BASELINES);
	assign raddr    = (state_q == ST_LOAD) ? loaded_q[AW-1:0] : bidx_q[AW-1:0];

	bsuvw_bl_mem #(.DEPTH(MAX_BASELINES), .AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(loaded_q[AW-1:0]),
		.wp(station_p), .wq(station_q),
		.wvec('{u: baseline_u, v: baseline_v, w: baseline_w}),
		.raddr(raddr), .rp(rp), .rq(rq), .rvec(rvec)
	);

	assign use_b = (rp != rq) && (SW'(rp) < n_q) && (SW'(rq) < n_q);
	assign kp    = known_q[rp];
	assign kq    = known_q[rq];

	// station coordinate reads: both baseline ends, or the station to emit
	assign sol_ra2 = (state_q == ST_EMIT) ? emit_q[IDX_W-1:0] : rq;
	always_ff @(posedge clk) begin
		sol_p_q <= sol_mem[rp];
		sol_q_q <= sol_mem[sol_ra2];
	end

	// coordinate writes
	always_ff @(posedge clk) begin
		if (state_q == ST_MARK && bidx_q == loaded_q && emit_q < n_q && known_q[emit_q[IDX_W-1:0]])
			sol_mem[emit_q[IDX_W-1:0]] <= '0;
		else if (state_q == ST_REF && ref_q < n_q && known_q[ref_q[IDX_W-1:0]] == 1'b0)
			sol_mem[ref_q[IDX_W-1:0]] <= '0;
		else if (state_q == ST_UPD && use_b && kp != kq) begin
			if (kp)
				sol_mem[rq] <= '{u: sat_addsub(sol_p_q.u, rvec.u, 1'b0),
					v: sat_addsub(sol_p_q.v, rvec.v, 1'b0),
					w: sat_addsub(sol_p_q.w, rvec.w, 1'b0)};
			else
				sol_mem[rp] <= '{u: sat_addsub(sol_q_q.u, rvec.u, 1'b1),
					v: sat_addsub(sol_q_q.v, rvec.v, 1'b1),
					w: sat_addsub(sol_q_q.w, rvec.w, 1'b1)};
		end
	end

	// output register, loaded from the fetched station
	always_ff @(posedge clk) begin
		if (emit_fetch_q) begin
			station_index <= emit_q[IDX_W-1:0];
			{station_u, station_v, station_w} <= sol_q_q;
			final_station <= (emit_q == n_q - SW'(1));
		end
	end

	// solve sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			loaded_q     <= '0;
			bidx_q       <= '0;
			n_q          <= SW'(1);
			ref_q        <= '0;
			found_q      <= '0;
			emit_q       <= '0;
			known_q      <= '1;
			reach_q      <= 1'b0;
			hold_q       <= 1'b0;
			emit_fetch_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					hold_q <= 1'b0;
					if (in_valid && !in_stall) begin
						if (mem_we)
							loaded_q <= loaded_q + CW'(1);
						if (last) begin
							state_q <= ST_MARK;
							n_q     <= n_eff;
							known_q <= '1;
							reach_q <= 1'b0;
							bidx_q  <= '0;
							emit_q  <= '0;
							hold_q  <= 1'b1;
						end
					end
				end
				ST_MARK: begin
					// mark pass over the baselines (ST_MARK, ST_MRK2), then zero the isolated stations
					if (bidx_q != loaded_q) begin
						state_q <= ST_MRK2;
					end else if (emit_q < n_q) begin
						emit_q <= emit_q + SW'(1);
					end else begin
						emit_q <= '0;
						ref_q  <= '0;
						state_q <= reach_q ? ST_REF : ST_EMIT;
					end
				end
				ST_MRK2: begin
					if (use_b) begin
						known_q <= known_q & ~((NS'(1) << rp) | (NS'(1) << rq));
						reach_q <= 1'b1;
					end
					bidx_q  <= bidx_q + CW'(1);
					state_q <= ST_MARK;
				end
				ST_REF: begin
					if (ref_q >= n_q) begin
						state_q <= ST_EMIT;
					end else if (known_q[ref_q[IDX_W-1:0]]) begin
						ref_q <= ref_q + SW'(1);
					end else begin
						known_q[ref_q[IDX_W-1:0]] <= 1'b1;
						if (ref_q == n_q - SW'(1)) begin
							state_q <= ST_EMIT;
						end else begin
							bidx_q  <= '0;
							found_q <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					// end of pass check, else wait for baseline read data
					if (bidx_q == loaded_q) begin
						if (found_q == '0 || found_q == n_q - ref_q - SW'(1)) begin
							state_q <= ST_REF;
						end else begin
							bidx_q  <= '0;
							found_q <= '0;
						end
					end else begin
						state_q <= ST_FET;
					end
				end
				ST_FET: begin
					// station coordinates of both ends are read here
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (use_b && kp != kq) begin
						if (kp)
							known_q[rq] <= 1'b1;
						else
							known_q[rp] <= 1'b1;
						found_q <= found_q + SW'(1);
					end
					bidx_q  <= bidx_q + CW'(1);
					state_q <= ST_RD;
				end
				ST_EMIT: begin
					// fetch one station per free output slot
					if (emit_fetch_q) begin
						emit_fetch_q <= 1'b0;
						out_valid    <= 1'b1;
						emit_q       <= emit_q + SW'(1);
					end else if (!out_valid || !out_stall) begin
						if (emit_q < n_q) begin
							emit_fetch_q <= 1'b1;
						end else begin
							loaded_q <= '0;
							state_q  <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ bench/bsuvw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsuvw_checker
// watches the config port and both item channels of the uvw solver, keeps its
// own baseline store and station solution, and compares every emitted station
// against the predicted one in order
// ----------------------------------------------------------------------------
module bsuvw_checker import bsuvw_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic                pready,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic [IDX_W-1:0]    station_p,
	input  wire logic [IDX_W-1:0]    station_q,
	input  wire logic signed [31:0]  baseline_u,
	input  wire logic signed [31:0]  baseline_v,
	input  wire logic signed [31:0]  baseline_w,
	input  wire logic                last,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic [IDX_W-1:0]    station_index,
	input  wire logic signed [31:0]  station_u,
	input  wire logic signed [31:0]  station_v,
	input  wire logic signed [31:0]  station_w,
	input  wire logic                final_station,
	output int                       fail_count,
	output int                       pending
);
	localparam int STATIONS  = 64;
	localparam int BASELINES = 4096;

	typedef struct {
		logic [IDX_W-1:0] idx;
		coord_t           u;
		coord_t           v;
		coord_t           w;
		logic             fin;
	} station_pos_t;

	// baseline store and solution
	logic [IDX_W-1:0] bl_p [BASELINES];
	logic [IDX_W-1:0] bl_q [BASELINES];
	coord_t           bl_u [BASELINES];
	coord_t           bl_v [BASELINES];
	coord_t           bl_w [BASELINES];
	int               n_loaded;
	bit               known [STATIONS];
	coord_t           pos_u [STATIONS];
	coord_t           pos_v [STATIONS];
	coord_t           pos_w [STATIONS];
	logic [6:0]       station_cfg;
	station_pos_t     stations_due [$];

	function automatic coord_t clamp_sum(coord_t a, coord_t b, bit neg);
		longint r;
		r = neg ? longint'(a) - longint'(b) : longint'(a) + longint'(b);
		if (r > 64'sd2147483647)
			return 32'sh7fffffff;
		if (r < -64'sd2147483648)
			return 32'sh80000000;
		return coord_t'(r);
	endfunction

	function automatic bit is_cross(int b, int n);
		return bl_p[b] != bl_q[b] && int'(bl_p[b]) < n && int'(bl_q[b]) < n;
	endfunction

	task automatic place(int s, coord_t u, coord_t v, coord_t w);
		pos_u[s] = u;
		pos_v[s] = v;
		pos_w[s] = w;
	endtask

	// group-by-group propagation from the lowest unknown station
	task automatic solve_stations(int n);
		int reach;
		int ref_st;
		int found;
		int p;
		int q;
		bit done;
		reach = 0;
		for (int s = 0; s < STATIONS; s++)
			known[s] = 1'b1;
		for (int b = 0; b < n_loaded; b++) begin
			if (!is_cross(b, n))
				continue;
			if (known[bl_p[b]]) begin
				known[bl_p[b]] = 1'b0;
				reach++;
			end
			if (known[bl_q[b]]) begin
				known[bl_q[b]] = 1'b0;
				reach++;
			end
		end
		for (int s = 0; s < n; s++)
			if (known[s])
				place(s, 0, 0, 0);
		if (reach == 0)
			return;
		ref_st = 0;
		while (1) begin
			while (ref_st < n && known[ref_st])
				ref_st++;
			if (ref_st == n)
				break;
			place(ref_st, 0, 0, 0);
			known[ref_st] = 1'b1;
			if (ref_st == n - 1)
				break;
			done = 1'b0;
			while (!done) begin
				found = 0;
				for (int b = 0; b < n_loaded; b++) begin
					p = bl_p[b];
					q = bl_q[b];
					if (!is_cross(b, n) || known[p] == known[q])
						continue;
					if (known[p]) begin
						place(q, clamp_sum(pos_u[p], bl_u[b], 1'b0),
							clamp_sum(pos_v[p], bl_v[b], 1'b0),
							clamp_sum(pos_w[p], bl_w[b], 1'b0));
						known[q] = 1'b1;
					end else begin
						place(p, clamp_sum(pos_u[q], bl_u[b], 1'b1),
							clamp_sum(pos_v[q], bl_v[b], 1'b1),
							clamp_sum(pos_w[q], bl_w[b], 1'b1));
						known[p] = 1'b1;
					end
					found++;
				end
				done = (found == 0 || found == n - ref_st - 1);
			end
		end
	endtask

	// load baselines and predict stations on the last item
	always @(posedge clk or negedge arst_n) begin
		int n;
		station_pos_t sp;
		if (!arst_n) begin
			station_cfg <= 7'd64;
			n_loaded = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_STATION_COUNT)
				station_cfg <= pwdata[6:0];
			if (in_valid && !in_stall) begin
				if (n_loaded < BASELINES) begin
					bl_p[n_loaded] = station_p;
					bl_q[n_loaded] = station_q;
					bl_u[n_loaded] = baseline_u;
					bl_v[n_loaded] = baseline_v;
					bl_w[n_loaded] = baseline_w;
					n_loaded++;
				end
				if (last) begin
					n = station_cfg;
					if (n < 1)
						n = 1;
					if (n > STATIONS)
						n = STATIONS;
					solve_stations(n);
					for (int s = 0; s < n; s++) begin
						sp.idx = IDX_W'(s);
						sp.u = pos_u[s];
						sp.v = pos_v[s];
						sp.w = pos_w[s];
						sp.fin = (s == n - 1);
						stations_due.insert(stations_due.size(), sp);
					end
					n_loaded = 0;
				end
			end
			// compare each emitted station with the oldest prediction
			if (out_valid && !out_stall) begin
				if (stations_due.size() == 0) begin
					$error("station item %0d with nothing predicted", station_index);
					fail_count <= fail_count + 1;
				end else begin
					sp = stations_due.pop_front();
					if (station_index !== sp.idx || station_u !== sp.u ||
						station_v !== sp.v || station_w !== sp.w ||
						final_station !== sp.fin)
						fail_count <= fail_count + 1;
					if (station_index !== sp.idx)
						$error("station_index exp %0d got %0d", sp.idx, station_index);
					if (station_u !== sp.u)
						$error("station_u exp %0d got %0d", sp.u, station_u);
					if (station_v !== sp.v)
						$error("station_v exp %0d got %0d", sp.v, station_v);
					if (station_w !== sp.w)
						$error("station_w exp %0d got %0d", sp.w, station_w);
					if (final_station !== sp.fin)
						$error("final_station exp %0d got %0d", sp.fin, final_station);
				end
			end
			pending <= stations_due.size();
		end
	end
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives baselines and station count settings into the uvw solver under
// random idling and stalling; the checker predicts and compares the stations
// ----------------------------------------------------------------------------
module tb_top;
	import bsuvw_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [1:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;
	logic             in_valid;
	logic             in_stall;
	logic [IDX_W-1:0] station_p;
	logic [IDX_W-1:0] station_q;
	coord_t           baseline_u;
	coord_t           baseline_v;
	coord_t           baseline_w;
	logic             last;
	logic             out_valid;
	logic             out_stall;
	logic [IDX_W-1:0] station_index;
	coord_t           station_u;
	coord_t           station_v;
	coord_t           station_w;
	logic             final_station;
	int               fail_count;
	int               pending;
	int               idle_pct;
	int               stall_pct;
	int               hold_left;
	int               n_items;
	int               n_cfg;

	baseline_to_station_uvw_solver dut (.*);

	bsuvw_checker u_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50ms;
		$display("Regression FAIL");
		$finish;
	end

	// receiver stalls, with one long hold
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic cfg_write(logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_STATION_COUNT;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		n_cfg = val[6:0];
	endtask

	task automatic send_baseline(int p, int q, coord_t u, coord_t v, coord_t w, bit l);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		station_p <= IDX_W'(p);
		station_q <= IDX_W'(q);
		baseline_u <= u;
		baseline_v <= v;
		baseline_w <= w;
		last <= l;
		do
			@(posedge clk);
		while (in_stall);
		n_items++;
	endtask

	// idle the sender until every predicted station has come out
	task automatic drain;
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic coord_t pick_coord;
		case ($urandom_range(7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	// one block of random baselines, mostly inside the station range
	task automatic random_block;
		int len;
		int span;
		int n_eff;
		n_eff = (n_cfg < 1) ? 1 : (n_cfg > 64 ? 64 : n_cfg);
		len = $urandom_range(10, 1);
		for (int k = 0; k < len; k++) begin
			span = ($urandom_range(9) == 0) ? 63 : n_eff - 1;
			send_baseline($urandom_range(span), $urandom_range(span),
				pick_coord(), pick_coord(), pick_coord(), k == len - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		station_p = '0;
		station_q = '0;
		baseline_u = '0;
		baseline_v = '0;
		baseline_w = '0;
		last = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		n_items = 0;
		n_cfg = 64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturating sums both ways, reverse fill, autocorrelation, out of range
		cfg_write(4);
		send_baseline(0, 1, 32'sh7fffffff, 32'sh80000000, 1, 1'b0);
		send_baseline(1, 2, 32'sh7fffffff, 32'sh80000000, -1, 1'b0);
		send_baseline(3, 2, 1, 2, 3, 1'b0);
		send_baseline(2, 2, 5, 5, 5, 1'b0);
		send_baseline(0, 5, 7, 7, 7, 1'b0);
		send_baseline(3, 0, 9, 9, 9, 1'b1);
		send_baseline(1, 0, 32'sh80000000, 32'sh7fffffff, 0, 1'b1);
		drain();
		// station count zero acts as one
		cfg_write(0);
		send_baseline(0, 0, 1, 1, 1, 1'b1);
		drain();
		// station count above range acts as 64, two separate groups
		cfg_write(127);
		send_baseline(63, 62, -1, 32'sh7fffffff, 32'sh80000000, 1'b0);
		send_baseline(62, 63, 4, 4, 4, 1'b0);
		send_baseline(10, 40, 32'sh55555555, 32'shaaaaaaaa, 123, 1'b0);
		send_baseline(40, 41, 1, 1, 1, 1'b1);
		drain();
		cfg_write(64);
		send_baseline(63, 0, 32'sh2aaaaaaa, 32'sh15555555, -7, 1'b1);
		send_baseline(7, 7, 0, 0, 0, 1'b1);
		drain();
		cfg_write(1);
		send_baseline(0, 1, 3, 3, 3, 1'b1);
		drain();
		cfg_write(64);

		// long receiver hold while the sender keeps going
		hold_left = 400;
		for (int b = 0; b < 3; b++)
			random_block();

		// random blocks over the idling and stalling phases
		while (n_items < 270) begin
			case (n_items * 4 / 270)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 67; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 67; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			if ($urandom_range(3) == 0) begin
				drain();
				case ($urandom_range(5))
					0: cfg_write(64);
					1: cfg_write($urandom_range(127, 65));
					2: cfg_write(1);
					default: cfg_write($urandom_range(10, 2));
				endcase
			end
			random_block();
		end
		drain();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/bsuvw_pkg.sv
hdl/bsuvw_bl_mem.sv
hdl/baseline_to_station_uvw_solver.sv
bench/bsuvw_checker.sv
bench/tb_top.sv
